>>> sv/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PSS_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PSS_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

>>> sv/pss_pkg.sv
// Package with codes, widths and shared types of the periodic service scheduler.
`default_nettype none
package pss_pkg;

  localparam int ID_W  = 16;
  localparam int PER_W = 16;
  localparam int DUE_W = 48;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVE = 2'd2;

  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

  typedef struct packed {
    logic             wen;
    logic             full_wr;
    logic [ID_W-1:0]  ident;
    logic [PER_W-1:0] period;
    logic [DUE_W-1:0] due;
  } pss_wr_t;

  typedef struct packed {
    logic             vld;
    logic [DUE_W-1:0] due;
    logic [ID_W-1:0]  ident;
    logic [PER_W-1:0] period;
  } pss_cand_t;

endpackage
`default_nettype wire

>>> sv/pss_cell.sv
// One table entry of the scheduler with its stage of the minimum search chain.
`default_nettype none
module pss_cell #(
  parameter int MAX_ENTRIES = 64,
  parameter int IDX         = 0,
  localparam int IW         = $clog2(MAX_ENTRIES),
  localparam int CW         = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pss_pkg::pss_wr_t    wr,
  input  wire logic [IW-1:0]       wr_idx,
  input  wire logic [CW-1:0]       count,
  input  wire pss_pkg::pss_cand_t  cand_in,
  input  wire logic [IW-1:0]       cand_idx_in,
  output pss_pkg::pss_cand_t       cand_out,
  output logic [IW-1:0]            cand_idx_out
);

  logic [pss_pkg::ID_W-1:0]  ident_r;
  logic [pss_pkg::PER_W-1:0] period_r;
  logic [pss_pkg::DUE_W-1:0] due_r;
  pss_pkg::pss_cand_t        cand_r, cand_nxt;
  logic [IW-1:0]             cand_idx_r, cand_idx_nxt;
  logic                      occupied;
  logic                      earlier;
  logic                      selected;

  assign occupied = CW'(IDX) < count;
  assign selected = wr.wen && (wr_idx == IW'(IDX));
  assign earlier  = (due_r < cand_in.due) ||
                    ((due_r == cand_in.due) && (ident_r < cand_in.ident));

  always_comb begin
    cand_nxt     = cand_in;
    cand_idx_nxt = cand_idx_in;
    if (occupied && (!cand_in.vld || earlier)) begin
      cand_nxt.vld    = 1'b1;
      cand_nxt.due    = due_r;
      cand_nxt.ident  = ident_r;
      cand_nxt.period = period_r;
      cand_idx_nxt    = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (selected) begin
      due_r <= wr.due;
      if (wr.full_wr) begin
        ident_r  <= wr.ident;
        period_r <= wr.period;
      end
    end
    if (!rst_n) begin
      cand_r.vld <= 1'b0;
    end else begin
      cand_r.vld <= cand_nxt.vld;
    end
    cand_r.due    <= cand_nxt.due;
    cand_r.ident  <= cand_nxt.ident;
    cand_r.period <= cand_nxt.period;
    cand_idx_r    <= cand_idx_nxt;
  end

  assign cand_out     = cand_r;
  assign cand_idx_out = cand_idx_r;

endmodule
`default_nettype wire

>>> sv/periodic_service_scheduler_top.sv
// Top level of the periodic service scheduler: command decode, table count and result register.
`default_nettype none
`include "assert_macros.svh"
// The client table is a row of MAX_ENTRIES cells, and a running best candidate moves one
// cell down the row per clock. A serve on a non-empty table holds the input while the scan
// runs through the cell row and while the result is handed over; an add or a serve on an
// empty table holds it while its result is handed over, and a clear does not hold it. The
// scan length through the cell row sets the serve time, and a result that is held in the
// output register delays the hand-over of the next one. A new transaction is taken while
// the previous result still waits in the output register.
module periodic_service_scheduler_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_client_id,
  input  wire logic [15:0] in_period,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_served_id,
  output logic [1:0]       out_status
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [IW-1:0]              scan_cnt_r, scan_cnt_nxt;
  logic [pss_pkg::ID_W-1:0]   res_id_r, res_id_nxt;
  logic [pss_pkg::ST_W-1:0]   res_status_r, res_status_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [pss_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [pss_pkg::ST_W-1:0]   out_status_r, out_status_nxt;

  pss_pkg::pss_wr_t           wr;
  logic [IW-1:0]              wr_idx;
  pss_pkg::pss_cand_t         cand_w [MAX_ENTRIES];
  logic [IW-1:0]              cand_idx_w [MAX_ENTRIES];
  pss_pkg::pss_cand_t         best;
  logic [pss_pkg::DUE_W:0]    due_sum;
  logic [pss_pkg::DUE_W-1:0]  due_adv;
  logic                       accept;
  logic                       full;
  logic                       scan_last;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        pss_cell #(.MAX_ENTRIES(MAX_ENTRIES), .IDX(g)) u_cell (
          .clk          (clk),
          .rst_n        (rst_n),
          .wr           (wr),
          .wr_idx       (wr_idx),
          .count        (count_r),
          .cand_in      ('0),
          .cand_idx_in  ('0),
          .cand_out     (cand_w[g]),
          .cand_idx_out (cand_idx_w[g])
        );
      end else begin : g_body
        pss_cell #(.MAX_ENTRIES(MAX_ENTRIES), .IDX(g)) u_cell (
          .clk          (clk),
          .rst_n        (rst_n),
          .wr           (wr),
          .wr_idx       (wr_idx),
          .count        (count_r),
          .cand_in      (cand_w[g-1]),
          .cand_idx_in  (cand_idx_w[g-1]),
          .cand_out     (cand_w[g]),
          .cand_idx_out (cand_idx_w[g])
        );
      end
    end
  endgenerate

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign scan_last = (scan_cnt_r == IW'(MAX_ENTRIES - 1));
  assign best      = cand_w[MAX_ENTRIES-1];
  assign due_sum   = {1'b0, best.due} + (pss_pkg::DUE_W + 1)'(best.period);
  assign due_adv   = due_sum[pss_pkg::DUE_W] ? pss_pkg::DUE_MAX : due_sum[pss_pkg::DUE_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_cnt_nxt   = scan_cnt_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    wr             = '0;
    wr_idx         = count_r[IW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            pss_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            pss_pkg::OP_ADD: begin
              res_id_nxt = '0;
              state_nxt  = ST_RESP;
              if (full) begin
                res_status_nxt = pss_pkg::STATUS_FULL;
              end else begin
                res_status_nxt = pss_pkg::STATUS_OK;
                wr.wen         = 1'b1;
                wr.full_wr     = 1'b1;
                wr.ident       = in_client_id;
                wr.period      = in_period;
                wr.due         = pss_pkg::DUE_W'(in_period);
                count_nxt      = count_r + CW'(1);
              end
            end
            pss_pkg::OP_SERVE: begin
              if (count_r == '0) begin
                res_id_nxt     = '0;
                res_status_nxt = pss_pkg::STATUS_EMPTY;
                state_nxt      = ST_RESP;
              end else begin
                scan_cnt_nxt = '0;
                state_nxt    = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + IW'(1);
        if (scan_last) begin
          wr.wen         = 1'b1;
          wr.full_wr     = 1'b0;
          wr.due         = due_adv;
          wr_idx         = cand_idx_w[MAX_ENTRIES-1];
          res_id_nxt     = best.ident;
          res_status_nxt = pss_pkg::STATUS_OK;
          state_nxt      = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = res_id_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r   <= scan_cnt_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_served_id = out_id_r;
  assign out_status    = out_status_r;

  `PSS_ASSERT(a_count_bound, count_r <= CW'(MAX_ENTRIES), "Client count exceeds table size.")
  `PSS_ASSERT(a_scan_nonempty, (state_r == ST_SCAN) |-> (count_r != '0), "Scan on an empty table.")
  `PSS_ASSERT(a_scan_found, (state_r == ST_SCAN && scan_last) |-> best.vld, "No client found.")
  `PSS_ASSERT(a_out_from_resp, $rose(out_valid_r) |-> $past(state_r == ST_RESP), "Stray result.")

endmodule
`default_nettype wire

>>> test/service_order_monitor.sv
// Watches both channels of the scheduler, predicts each result and compares it field by field.
`default_nettype none
module service_order_monitor #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_client_id,
  input  wire logic [15:0] in_period,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_served_id,
  input  wire logic [1:0]  out_status,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [pss_pkg::ID_W-1:0] served_id;
    logic [pss_pkg::ST_W-1:0] status;
  } grant_t;

  logic [pss_pkg::ID_W-1:0]  tab_ident  [MAX_ENTRIES];
  logic [pss_pkg::PER_W-1:0] tab_period [MAX_ENTRIES];
  logic [pss_pkg::DUE_W-1:0] tab_due    [MAX_ENTRIES];
  int                        tab_count;
  grant_t                    grant_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    tab_count   = 0;
  end

  // Applies one transaction to the shadow table and returns whether it yields a result.
  function automatic logic predict_grant(input logic [pss_pkg::OP_W-1:0] op,
                                         input logic [pss_pkg::ID_W-1:0] cid,
                                         input logic [pss_pkg::PER_W-1:0] per,
                                         output grant_t g);
    int                      best;
    logic [pss_pkg::DUE_W:0] sum;
    g = '0;
    g.status = pss_pkg::STATUS_OK;
    predict_grant = 1'b0;
    case (op)
      pss_pkg::OP_CLEAR: begin
        tab_count = 0;
      end
      pss_pkg::OP_ADD: begin
        predict_grant = 1'b1;
        if (tab_count >= MAX_ENTRIES) begin
          g.status = pss_pkg::STATUS_FULL;
        end else begin
          tab_ident[tab_count]  = cid;
          tab_period[tab_count] = per;
          tab_due[tab_count]    = pss_pkg::DUE_W'(per);
          tab_count++;
        end
      end
      pss_pkg::OP_SERVE: begin
        predict_grant = 1'b1;
        if (tab_count == 0) begin
          g.status = pss_pkg::STATUS_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < tab_count; i++) begin
            if (tab_due[i] < tab_due[best] ||
                (tab_due[i] == tab_due[best] && tab_ident[i] < tab_ident[best])) begin
              best = i;
            end
          end
          sum = {1'b0, tab_due[best]} + (pss_pkg::DUE_W+1)'(tab_period[best]);
          tab_due[best] = sum[pss_pkg::DUE_W] ? pss_pkg::DUE_MAX
                                              : sum[pss_pkg::DUE_W-1:0];
          g.served_id = tab_ident[best];
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_failure(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    grant_t want;
    grant_t pred;
    if (!rst_n) begin
      tab_count = 0;
      grant_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          report_failure($sformatf("unexpected result: served_id %0h status %0d",
                                   out_served_id, out_status));
        end else begin
          want = grant_q.pop_front();
          if (out_served_id !== want.served_id) begin
            report_failure($sformatf("served_id mismatch: expected %0h, got %0h",
                                     want.served_id, out_served_id));
          end
          if (out_status !== want.status) begin
            report_failure($sformatf("status mismatch: expected %0d, got %0d",
                                     want.status, out_status));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (predict_grant(in_op, in_client_id, in_period, pred)) begin
          grant_q.insert(grant_q.size(), pred);
        end
      end
    end
    outstanding <= grant_q.size();
  end

endmodule
`default_nettype wire

>>> test/tb.sv
// Testbench top: drives commands into the scheduler, stalls the result side and gives the verdict.
`default_nettype none
module tb;

  localparam int                       MAX_ENTRIES = 64;
  localparam int                       ITEM_TARGET = 900;
  localparam int                       HOLD_CYCLES = 400;
  localparam logic [pss_pkg::OP_W-1:0] OP_IGNORED  = 2'd3;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [1:0]  in_op        = pss_pkg::OP_CLEAR;
  logic [15:0] in_client_id = '0;
  logic [15:0] in_period    = '0;
  logic        rx_stall     = 1'b0;
  logic        rx_hold      = 1'b0;
  wire         out_stall    = rx_stall | rx_hold;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_served_id;
  logic [1:0]  out_status;
  logic        quiet        = 1'b0;
  int          sent_items   = 0;
  int          fail_count;
  int          outstanding;

  periodic_service_scheduler_top #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_client_id (in_client_id),
    .in_period    (in_period),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_served_id(out_served_id),
    .out_status   (out_status)
  );

  service_order_monitor #(.MAX_ENTRIES(MAX_ENTRIES)) order_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_client_id (in_client_id),
    .in_period    (in_period),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_served_id(out_served_id),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 500_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic issue(input logic [pss_pkg::OP_W-1:0] op, input logic [15:0] cid,
                       input logic [15:0] per);
    int gap;
    gap = quiet ? 0 : int'($urandom_range(0, 15));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_client_id <= cid;
    in_period    <= per;
    do @(posedge clk); while (in_stall);
    if (op != OP_IGNORED) sent_items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : drain
    int wait_cycles;
    forever begin
      wait_cycles = quiet ? 0 : int'($urandom_range(0, 15));
      if (wait_cycles > 0) begin
        rx_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // The result side holds off for a long stretch so that the block backs up into its input.
  initial begin
    wait (sent_items >= 300);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    int                       phase;
    int                       fill;
    int                       mix;
    int                       r;
    bit                       narrow_ids;
    bit                       short_periods;
    logic [pss_pkg::OP_W-1:0] op;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    issue(pss_pkg::OP_SERVE, 16'hFFFF, 16'hFFFF);
    issue(OP_IGNORED, 16'hFFFF, 16'hFFFF);
    issue(pss_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
    issue(pss_pkg::OP_ADD, 16'h0000, 16'h0001);
    issue(pss_pkg::OP_ADD, 16'h0005, 16'h0000);
    issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);
    issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);
    issue(pss_pkg::OP_ADD, 16'h0003, 16'h0000);
    issue(pss_pkg::OP_ADD, 16'h0003, 16'h0000);
    issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);
    issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);
    issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);
    issue(pss_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
    issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);
    issue(pss_pkg::OP_ADD, 16'h0007, 16'h0001);
    issue(pss_pkg::OP_ADD, 16'h0002, 16'h0002);
    issue(pss_pkg::OP_ADD, 16'h8000, 16'h8000);
    repeat (4) issue(pss_pkg::OP_SERVE, 16'h0000, 16'h0000);

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      quiet         = ($urandom_range(0, 4) == 0);
      narrow_ids    = 1'($urandom_range(0, 1));
      short_periods = 1'($urandom_range(0, 1));
      if (phase == 0 || $urandom_range(0, 4) != 0) begin
        issue(pss_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
        fill = (phase == 0) ? MAX_ENTRIES + 3 : int'($urandom_range(1, MAX_ENTRIES + 4));
        repeat (fill) begin
          issue(pss_pkg::OP_ADD,
                narrow_ids ? 16'($urandom_range(0, 7)) : 16'($urandom),
                short_periods ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 65535)));
        end
      end
      mix = int'($urandom_range(10, 60));
      repeat (mix) begin
        r = int'($urandom_range(0, 99));
        if (r < 60) op = pss_pkg::OP_SERVE;
        else if (r < 85) op = pss_pkg::OP_ADD;
        else if (r < 92) op = pss_pkg::OP_CLEAR;
        else op = OP_IGNORED;
        if (op == pss_pkg::OP_ADD) begin
          issue(op,
                narrow_ids ? 16'($urandom_range(0, 7)) : 16'($urandom),
                short_periods ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 65535)));
        end else begin
          issue(op, 16'($urandom), 16'($urandom));
        end
      end
      if (phase == 2 || $urandom_range(0, 3) == 0) settle();
      phase++;
    end
    in_valid <= 1'b0;
    quiet = 1'b1;

    settle();
    repeat (2 * MAX_ENTRIES + 10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
